[sv/actr_pkg.sv]
// Shared types, constants and AES round functions for the AES-256 CTR keystream block.
// No dependencies.
package actr_pkg;

    localparam int NR = 14;
    localparam int RK_WORDS = 4 * (NR + 1);

    typedef enum logic [2:0] {
        REG_KEY0    = 3'd0,
        REG_KEY1    = 3'd1,
        REG_KEY2    = 3'd2,
        REG_KEY3    = 3'd3,
        REG_IV_HIGH = 3'd4,
        REG_IV_LOW  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic        last_in;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic        last_out;
    } t_out_item;

    typedef struct packed {
        logic [127:0] state;
        logic [127:0] data;
        logic         last;
    } t_stage;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte k of the block sits at bits [127-8k -: 8]
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = s[127 - 32 * c -: 8];
            a1  = s[119 - 32 * c -: 8];
            a2  = s[111 - 32 * c -: 8];
            a3  = s[103 - 32 * c -: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

endpackage

[sv/aes256_ctr_keystream_xor.sv]
// AES-256 CTR keystream XOR: initial key add, 13 round cells, final round with output XOR.
// Depends on actr_pkg, actr_keyexp, actr_cell.
//
//  channel | valid       | stall        | payload
//  input   | i_in_valid  | o_in_stall   | i_in_item  (t_in_item)
//  output  | o_out_valid | i_out_stall  | o_out_item (t_out_item)
//  config  | i_cfg_we    | -            | i_cfg_index, i_cfg_data
//
// One item per cycle while o_in_stall is low; stages: key add stage, 13 round cells, final round.
// A key word write runs the schedule, with o_in_stall high until it completes.
// After reset the round keys are undefined until a key word is written.
// i_out_stall freezes the whole cell chain while o_out_valid is high; o_in_stall follows in the same cycle.
module aes256_ctr_keystream_xor import actr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [63:0]       r_key [4];
    logic [63:0]       r_iv_high;
    logic [63:0]       r_ctr;
    logic              w_key_wr;
    logic              w_busy;
    logic [NR:0][127:0] w_rk;
    logic              w_en;
    logic              w_accept;
    logic              r_v0;
    t_stage            r_s0;
    logic   [NR-2:0]   w_v;
    t_stage [NR-2:0]   w_s;
    logic              r_out_valid;
    t_out_item         r_out;
    logic [127:0]      w_ks;

    assign w_en       = !r_out_valid || !i_out_stall;
    assign o_in_stall = w_busy || !w_en;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_key_wr   = i_cfg_we && (i_cfg_index == REG_KEY0 || i_cfg_index == REG_KEY1 ||
                                     i_cfg_index == REG_KEY2 || i_cfg_index == REG_KEY3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 4; j++) begin
                r_key[j] <= '0;
            end
            r_iv_high <= '0;
            r_ctr     <= '0;
        end else begin
            if (w_accept) begin
                r_ctr <= r_ctr + 64'd1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_KEY0:    r_key[0]  <= i_cfg_data;
                    REG_KEY1:    r_key[1]  <= i_cfg_data;
                    REG_KEY2:    r_key[2]  <= i_cfg_data;
                    REG_KEY3:    r_key[3]  <= i_cfg_data;
                    REG_IV_HIGH: r_iv_high <= i_cfg_data;
                    REG_IV_LOW:  r_ctr     <= i_cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    actr_keyexp u_keyexp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_key_wr),
        .i_key   ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .o_busy  (w_busy),
        .o_rk    (w_rk)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0.state <= {r_iv_high, r_ctr} ^ w_rk[0];
            r_s0.data  <= {i_in_item.data_high, i_in_item.data_low};
            r_s0.last  <= i_in_item.last_in;
        end
    end

    for (genvar g = 0; g < NR - 1; g++) begin : g_cell
        actr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid ((g == 0) ? r_v0 : w_v[g - 1 + (g == 0)]),
            .i_stage ((g == 0) ? r_s0 : w_s[g - 1 + (g == 0)]),
            .i_rk    (w_rk[g + 1]),
            .o_valid (w_v[g]),
            .o_stage (w_s[g])
        );
    end

    assign w_ks = sub_shift(w_s[NR-2].state) ^ w_rk[NR];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_v[NR-2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.result_high <= w_s[NR-2].data[127:64] ^ w_ks[127:64];
            r_out.result_low  <= w_s[NR-2].data[63:0] ^ w_ks[63:0];
            r_out.last_out    <= w_s[NR-2].last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_key_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_key_wr |=> w_busy) else $error("schedule not started on key write");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_accept) else $error("item accepted during key expansion");

    a_ctr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !(i_cfg_we && i_cfg_index == REG_IV_LOW)) |=>
        r_ctr == $past(r_ctr) + 64'd1) else $error("counter did not advance");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("output changed while stalled");

endmodule

[sv/actr_keyexp.sv]
// AES-256 key schedule: one round-key word per cycle after a key write, 60 words stored.
// Depends on actr_pkg.
module actr_keyexp import actr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [255:0]         i_key,
    output logic                 o_busy,
    output logic [NR:0][127:0]   o_rk
);

    logic [31:0] r_rk  [RK_WORDS];
    logic [31:0] r_win [8];
    logic [5:0]  r_idx;
    logic [7:0]  r_rcon;
    logic        r_busy;
    logic [31:0] n_word;
    logic [31:0] w_t;

    always_comb begin
        w_t = r_win[7];
        if (r_idx[2:0] == 3'd0) begin
            w_t = sub_word({r_win[7][23:0], r_win[7][31:24]}) ^ {r_rcon, 24'h0};
        end else if (r_idx[2:0] == 3'd4) begin
            w_t = sub_word(r_win[7]);
        end
        n_word = r_win[0] ^ w_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy) begin
            if (r_idx == 6'd0) begin
                r_idx <= 6'd8;
            end else if (r_idx == 6'(RK_WORDS - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !i_start) begin
            if (r_idx == 6'd0) begin
                for (int j = 0; j < 8; j++) begin
                    r_win[j] <= i_key[255 - 32 * j -: 32];
                    r_rk[j]  <= i_key[255 - 32 * j -: 32];
                end
                r_rcon <= 8'h01;
            end else begin
                for (int j = 0; j < 7; j++) begin
                    r_win[j] <= r_win[j + 1];
                end
                r_win[7]     <= n_word;
                r_rk[r_idx]  <= n_word;
                if (r_idx[2:0] == 3'd0) begin
                    r_rcon <= xtime(r_rcon);
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r <= NR; r++) begin
            o_rk[r] = {r_rk[4 * r], r_rk[4 * r + 1], r_rk[4 * r + 2], r_rk[4 * r + 3]};
        end
    end

    assign o_busy = r_busy;

endmodule

[sv/actr_cell.sv]
// One full AES round cell: SubBytes, ShiftRows, MixColumns, AddRoundKey, registered.
// Depends on actr_pkg.
module actr_cell import actr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  t_stage       i_stage,
    input  logic [127:0] i_rk,
    output logic         o_valid,
    output t_stage       o_stage
);

    logic   r_valid;
    t_stage r_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage.state <= mix_columns(sub_shift(i_stage.state)) ^ i_rk;
            r_stage.data  <= i_stage.data;
            r_stage.last  <= i_stage.last;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

[tb/testbench.sv]
// Self-checking bench for aes256_ctr_keystream_xor: AES-256 CTR keystream XOR with a
// scoreboard class holding its own cipher model. Depends on actr_pkg (ports, reg enum).
`timescale 1ns / 100ps
module testbench;
    import actr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LATENCY = 15;
    localparam int KEYEXP_CYCLES = 60;

    class ctr_scoreboard;
        logic [63:0]  key_w [4];
        logic [63:0]  nonce;
        logic [63:0]  ctr;
        logic [31:0]  rk [60];
        t_out_item    pending [$];
        int           errors;
        int           checked;

        function new();
            for (int i = 0; i < 4; i++) key_w[i] = '0;
            nonce = '0;
            ctr = '0;
            errors = 0;
            checked = 0;
        endfunction

        function logic [7:0] sb(input logic [7:0] b);
            logic [7:0] tbl [256];
            tbl = '{
            8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
            8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
            8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
            8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
            8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
            8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
            8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
            8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
            8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
            8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
            8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
            8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
            8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
            8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
            8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
            8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
            return tbl[b];
        endfunction

        function logic [7:0] dbl(input logic [7:0] b);
            return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
        endfunction

        function logic [31:0] subw(input logic [31:0] w);
            return {sb(w[31:24]), sb(w[23:16]), sb(w[15:8]), sb(w[7:0])};
        endfunction

        function void build_schedule();
            logic [31:0] t;
            logic [7:0]  rc;
            rc = 8'h01;
            for (int i = 0; i < 4; i++) begin
                rk[2 * i] = key_w[i][63:32];
                rk[2 * i + 1] = key_w[i][31:0];
            end
            for (int i = 8; i < 60; i++) begin
                t = rk[i - 1];
                if (i % 8 == 0) begin
                    t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                    rc = dbl(rc);
                end else if (i % 8 == 4) begin
                    t = subw(t);
                end
                rk[i] = rk[i - 8] ^ t;
            end
        endfunction

        function void write_reg(input t_reg_idx idx, input logic [63:0] v);
            case (idx)
                REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
                    key_w[idx] = v;
                    build_schedule();
                end
                REG_IV_HIGH: nonce = v;
                REG_IV_LOW: ctr = v;
                default: ;
            endcase
        endfunction

        // byte k at [127-8k -: 8], column c = bytes 4c..4c+3
        function logic [127:0] cipher(input logic [127:0] s);
            logic [127:0] t;
            logic [7:0]   a0, a1, a2, a3, x;
            s = s ^ {rk[0], rk[1], rk[2], rk[3]};
            for (int rnd = 1; rnd <= 14; rnd++) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[127 - 8 * (4 * c + r) -: 8] =
                            sb(s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]);
                s = t;
                if (rnd < 14) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = s[127 - 32 * c -: 8];
                        a1 = s[119 - 32 * c -: 8];
                        a2 = s[111 - 32 * c -: 8];
                        a3 = s[103 - 32 * c -: 8];
                        x = a0 ^ a1 ^ a2 ^ a3;
                        s[127 - 32 * c -: 8] = a0 ^ x ^ dbl(a0 ^ a1);
                        s[119 - 32 * c -: 8] = a1 ^ x ^ dbl(a1 ^ a2);
                        s[111 - 32 * c -: 8] = a2 ^ x ^ dbl(a2 ^ a3);
                        s[103 - 32 * c -: 8] = a3 ^ x ^ dbl(a3 ^ a0);
                    end
                end
                s = s ^ {rk[4 * rnd], rk[4 * rnd + 1], rk[4 * rnd + 2], rk[4 * rnd + 3]};
            end
            return s;
        endfunction

        function void note_block(input t_in_item it);
            logic [127:0] ks;
            t_out_item    o;
            ks = cipher({nonce, ctr});
            o.result_high = it.data_high ^ ks[127:64];
            o.result_low = it.data_low ^ ks[63:0];
            o.last_out = it.last_in;
            pending.push_back(o);
            ctr = ctr + 64'd1;
        endfunction

        function void check_block(input t_out_item got);
            t_out_item e;
            checked++;
            if (pending.size() == 0) begin
                $error("unexpected output item %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.result_high !== e.result_high) begin
                $error("result_high expected %h actual %h", e.result_high, got.result_high);
                errors++;
            end
            if (got.result_low !== e.result_low) begin
                $error("result_low expected %h actual %h", e.result_low, got.result_low);
                errors++;
            end
            if (got.last_out !== e.last_out) begin
                $error("last_out expected %b actual %b", e.last_out, got.last_out);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_stall;
    t_out_item   out_item;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    aes256_ctr_keystream_xor dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    ctr_scoreboard sb_ctr = new();
    int  send_idle_pct;
    int  stall_pct;
    bit  hold_off;
    int  cycles;
    int  sent;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb_ctr.check_block(out_item);
        out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] edge64();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            default: return rand64();
        endcase
    endfunction

    // write enable drops after each write and the task idles before returning, so writes never come back to back
    task automatic cfg_write(input t_reg_idx idx, input logic [63:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        sb_ctr.write_reg(idx, v);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb_ctr.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // valid stays high after an accept; the idle loop or drain drops it
    task automatic send_block(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb_ctr.note_block(it);
        sent++;
    endtask

    task automatic send_rand(input int n, input bit extremes);
        t_in_item it;
        for (int i = 0; i < n; i++) begin
            it.data_high = extremes ? edge64() : rand64();
            it.data_low = extremes ? edge64() : rand64();
            it.last_in = $urandom_range(1);
            send_block(it);
        end
    endtask

    task automatic set_key(input logic [63:0] k0, k1, k2, k3);
        cfg_write(REG_KEY0, k0);
        cfg_write(REG_KEY1, k1);
        cfg_write(REG_KEY2, k2);
        cfg_write(REG_KEY3, k3);
        repeat (KEYEXP_CYCLES) @(posedge clk);
    endtask

    initial begin
        t_in_item it;
        cycles = 0;
        sent = 0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_KEY0;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: sample key, all-zero and all-one data, counter wrap
        set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        cfg_write(REG_IV_HIGH, 64'h0011223344556677);
        cfg_write(REG_IV_LOW, 64'h8899aabbccddeeff);
        it = '0;
        send_block(it);
        it = '1;
        send_block(it);
        drain();
        cfg_write(REG_IV_HIGH, '1);
        cfg_write(REG_IV_LOW, 64'hffff_ffff_ffff_fffe);
        send_rand(4, 1'b1);
        drain();
        cfg_write(REG_KEY2, '1);
        repeat (KEYEXP_CYCLES) @(posedge clk);
        cfg_write(REG_IV_HIGH, '0);
        cfg_write(REG_IV_LOW, '0);
        send_rand(8, 1'b1);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 24 : 72) : 0;
            stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 24 : 72) : 0;
            if (ph == 2) set_key('1, '1, '1, '1);
            else set_key(rand64(), rand64(), rand64(), rand64());
            cfg_write(REG_IV_HIGH, rand64());
            cfg_write(REG_IV_LOW, (ph == 3) ? 64'hffff_ffff_ffff_fff0 : rand64());
            if (ph == 0) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (80) @(posedge clk);
                        hold_off = 1'b0;
                    end
                    send_rand(60, 1'b0);
                join
            end
            send_rand(220, 1'b0);
            drain();
        end

        if (sb_ctr.pending.size() != 0) begin
            $error("%0d expected items never arrived", sb_ctr.pending.size());
            sb_ctr.errors++;
        end
        $display("Ran %0d blocks through several keys and counters, incl. wrap and stalls;",
                 sent);
        $display("%0d output items checked, %0d errors.", sb_ctr.checked, sb_ctr.errors);
        if (sb_ctr.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
